[src/lsau_pkg.sv]
`timescale 1ns / 1ps

package lsau_pkg;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	localparam logic [1:0] SHIFT_LSL = 2'd0;
	localparam logic [1:0] SHIFT_LSR = 2'd1;
	localparam logic [1:0] SHIFT_ASR = 2'd2;
	localparam logic [1:0] SHIFT_ROR = 2'd3;

	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_CS = 4'd2;
	localparam logic [3:0] COND_CC = 4'd3;
	localparam logic [3:0] COND_MI = 4'd4;
	localparam logic [3:0] COND_PL = 4'd5;
	localparam logic [3:0] COND_VS = 4'd6;
	localparam logic [3:0] COND_VC = 4'd7;
	localparam logic [3:0] COND_HI = 4'd8;
	localparam logic [3:0] COND_LS = 4'd9;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;
	localparam logic [3:0] COND_NV = 4'd15;

	localparam logic [3:0] HALF_OPCODE = 4'hB;

	// One classified instruction waiting for address generation.
	typedef struct packed {
		logic        cond_pass;
		logic        undefined;
		logic        is_load;
		logic [1:0]  access_size;
		logic        pre_index;
		logic        up;
		logic        writeback_en;
		logic [31:0] base_value;
		logic [31:0] offset;
		logic [31:0] store_data;
		logic [3:0]  dest_reg;
		logic [3:0]  writeback_reg;
	} lsau_entry_t;

endpackage

[src/lsau_if.sv]
`timescale 1ns / 1ps

interface lsau_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic [31:0] base_value;
	logic [31:0] offset_value;
	logic [31:0] store_value;
	logic [3:0]  flags;

	modport source (output valid, output instruction, output base_value,
		output offset_value, output store_value, output flags, input ready);
	modport sink (input valid, input instruction, input base_value,
		input offset_value, input store_value, input flags, output ready);
endinterface

interface lsau_rsp_if;
	logic        valid;
	logic        ready;
	logic        cond_pass;
	logic        is_load;
	logic [1:0]  access_size;
	logic [31:0] address;
	logic [31:0] store_data;
	logic [3:0]  dest_reg;
	logic        writeback_en;
	logic [3:0]  writeback_reg;
	logic [31:0] writeback_value;
	logic        undefined;

	modport source (output valid, output cond_pass, output is_load, output access_size,
		output address, output store_data, output dest_reg, output writeback_en,
		output writeback_reg, output writeback_value, output undefined, input ready);
	modport sink (input valid, input cond_pass, input is_load, input access_size,
		input address, input store_data, input dest_reg, input writeback_en,
		input writeback_reg, input writeback_value, input undefined, output ready);
endinterface

[src/lsau_front.sv]
`timescale 1ns / 1ps

module lsau_front import lsau_pkg::*; (
	input  logic [31:0] instruction,
	input  logic [31:0] base_value,
	input  logic [31:0] offset_value,
	input  logic [31:0] store_value,
	input  logic [3:0]  flags,
	output lsau_entry_t entry
);

	logic        n_flag, z_flag, c_flag, v_flag;
	logic [3:0]  cond;
	logic        cond_ok;
	logic        is_half, is_bw, undef;
	logic [4:0]  amount;
	logic [31:0] shifted;
	logic [63:0] rot_pair;
	logic [31:0] offset;
	logic [1:0]  size;
	logic [31:0] sdata;
	logic        pass;

	assign n_flag = flags[3];
	assign z_flag = flags[2];
	assign c_flag = flags[1];
	assign v_flag = flags[0];
	assign cond = instruction[31:28];

	always_comb begin
		case (cond)
			COND_EQ: cond_ok = z_flag;
			COND_NE: cond_ok = !z_flag;
			COND_CS: cond_ok = c_flag;
			COND_CC: cond_ok = !c_flag;
			COND_MI: cond_ok = n_flag;
			COND_PL: cond_ok = !n_flag;
			COND_VS: cond_ok = v_flag;
			COND_VC: cond_ok = !v_flag;
			COND_HI: cond_ok = c_flag && !z_flag;
			COND_LS: cond_ok = !c_flag || z_flag;
			COND_GE: cond_ok = (n_flag == v_flag);
			COND_LT: cond_ok = (n_flag != v_flag);
			COND_GT: cond_ok = (n_flag == v_flag) && !z_flag;
			COND_LE: cond_ok = (n_flag != v_flag) || z_flag;
			COND_AL: cond_ok = 1'b1;
			default: cond_ok = 1'b0;
		endcase
	end

	assign amount = instruction[11:7];
	assign rot_pair = {offset_value, offset_value} >> amount;

	always_comb begin
		case (instruction[6:5])
			SHIFT_LSL: shifted = offset_value << amount;
			SHIFT_LSR: shifted = (amount == 5'd0) ? 32'd0 : (offset_value >> amount);
			SHIFT_ASR: shifted = (amount == 5'd0) ? {32{offset_value[31]}}
				: 32'($signed(offset_value) >>> amount);
			default:   shifted = (amount == 5'd0) ? {c_flag, offset_value[31:1]}
				: rot_pair[31:0];
		endcase
	end

	assign is_half = (instruction[27:25] == 3'b000) && (instruction[7:4] == HALF_OPCODE);
	assign is_bw = (instruction[27:26] == 2'b01);

	always_comb begin
		undef = (cond == COND_NV);
		offset = 32'd0;
		size = instruction[22] ? SIZE_BYTE : SIZE_WORD;
		if (is_half) begin
			size = SIZE_HALF;
			offset = instruction[22] ? {24'd0, instruction[11:8], instruction[3:0]}
				: offset_value;
			if (!instruction[24] && instruction[21]) begin
				undef = 1'b1;
			end
		end else if (is_bw) begin
			if (instruction[25]) begin
				offset = shifted;
				if (instruction[4]) begin
					undef = 1'b1;
				end
			end else begin
				offset = {20'd0, instruction[11:0]};
			end
		end else begin
			undef = 1'b1;
		end
	end

	always_comb begin
		case (size)
			SIZE_BYTE: sdata = {24'd0, store_value[7:0]};
			SIZE_HALF: sdata = {16'd0, store_value[15:0]};
			default:   sdata = store_value;
		endcase
		if (instruction[20] || undef) begin
			sdata = 32'd0;
		end
	end

	assign pass = !undef && cond_ok;

	assign entry.cond_pass = pass;
	assign entry.undefined = undef;
	assign entry.is_load = instruction[20];
	assign entry.access_size = size;
	assign entry.pre_index = instruction[24];
	assign entry.up = instruction[23];
	assign entry.writeback_en = pass && (!instruction[24] || instruction[21]);
	assign entry.base_value = base_value;
	assign entry.offset = offset;
	assign entry.store_data = sdata;
	assign entry.dest_reg = instruction[15:12];
	assign entry.writeback_reg = instruction[19:16];

endmodule

[src/lsau_queue.sv]
`timescale 1ns / 1ps

module lsau_queue import lsau_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  lsau_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop_ready,
	output lsau_entry_t pop_entry
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	lsau_entry_t     slots_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push, pop;

	assign push_ready = (count_q != FullCnt);
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/lsau_back.sv]
`timescale 1ns / 1ps

module lsau_back import lsau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        entry_valid,
	output logic        entry_ready,
	input  lsau_entry_t entry,
	lsau_rsp_if.source  rsp
);

	logic [31:0] new_base;
	logic        valid_q;
	logic        take;

	assign new_base = entry.up ? entry.base_value + entry.offset
		: entry.base_value - entry.offset;
	assign entry_ready = !valid_q || rsp.ready;
	assign take = entry_valid && entry_ready;
	assign rsp.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (entry_ready) begin
			valid_q <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp.cond_pass <= entry.cond_pass;
			rsp.is_load <= entry.is_load;
			rsp.access_size <= entry.access_size;
			rsp.address <= entry.undefined ? 32'd0
				: (entry.pre_index ? new_base : entry.base_value);
			rsp.store_data <= entry.store_data;
			rsp.dest_reg <= entry.dest_reg;
			rsp.writeback_en <= entry.writeback_en;
			rsp.writeback_reg <= entry.writeback_reg;
			rsp.writeback_value <= entry.writeback_en ? new_base : 32'd0;
			rsp.undefined <= entry.undefined;
		end
	end

endmodule

[src/load_store_address_unit.sv]
`timescale 1ns / 1ps
// An accepted transaction is written into the decode queue, then registered onto rsp when the result register is free.
// Throughput: one transaction per cycle, with no stall while rsp is ready.
// The decode queue holds QUEUE_DEPTH entries, so the request side keeps flowing
// for that many transactions while rsp is stalled, one more if no result is waiting.
// Reset (arst_n low) empties the queue and drops the pending result; no clearing pass.

module load_store_address_unit import lsau_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	lsau_req_if.sink   req,
	lsau_rsp_if.source rsp
);

	lsau_entry_t front_entry;
	lsau_entry_t queue_entry;
	logic        queue_valid;
	logic        queue_ready;

	lsau_front u_front (
		.instruction  (req.instruction),
		.base_value   (req.base_value),
		.offset_value (req.offset_value),
		.store_value  (req.store_value),
		.flags        (req.flags),
		.entry        (front_entry)
	);

	lsau_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (req.valid),
		.push_ready (req.ready),
		.push_entry (front_entry),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_entry  (queue_entry)
	);

	lsau_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (queue_valid),
		.entry_ready (queue_ready),
		.entry       (queue_entry),
		.rsp         (rsp)
	);

endmodule
